// ----- src/dcs_pkg.sv -----
package dcs_pkg;

  // Widths of the channel fields.
  localparam int unsigned TRIAL_W   = 32;
  localparam int unsigned FINE_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DBL_W     = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_BITS     = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [CFG_DATA_W-1:0] INITIAL_COUNT_RST = 32'd4096;
  localparam logic [FINE_W-1:0]     FINE_BITS_RST     = 5'd8;

  // Input word mode codes.
  localparam logic MODE_START  = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  // Doublings counter saturates here.
  localparam logic [DBL_W-1:0] DBL_MAX = 6'd63;

  typedef struct packed {
    logic [TRIAL_W-1:0] trial_count;
    logic               done_res;
    logic               overflow;
  } result_t;

endpackage

// ----- src/dcs_in_if.sv -----
interface dcs_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic tick_passed;

  modport source (output valid, output mode, output tick_passed, input ready);
  modport sink (input valid, input mode, input tick_passed, output ready);
endinterface

// ----- src/dcs_out_if.sv -----
interface dcs_out_if import dcs_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [TRIAL_W-1:0] trial_count;
  logic               done_res;
  logic               overflow;

  modport source (output valid, output trial_count, output done_res, output overflow,
                  input ready);
  modport sink (input valid, input trial_count, input done_res, input overflow,
                output ready);
endinterface

// ----- src/dcs_cfg_if.sv -----
interface dcs_cfg_if import dcs_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/delay_count_calibration_search.sv -----
// A result word is loaded into the output register as its input word is taken.
// Throughput: one input word per cycle; the only stall is a full output register not taken.
// All per-word work is one pass of shift, mask and compare logic on the search registers.
// Reset (rst_n low, synchronous): search stage idle, count, probe bit and counters zero,
// initial_count 4096, fine_bits 8, output register empty. Configuration is always ready.
module delay_count_calibration_search import dcs_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  dcs_in_if.sink    in_ch,
  dcs_out_if.source out_ch,
  dcs_cfg_if.sink   cfg_ch
);

  // Search stages.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_COARSE = 2'd1;
  localparam logic [1:0] ST_FINE   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  localparam logic [COUNT_WIDTH-1:0] CNT_ONE     = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] CNT_RESTART = COUNT_WIDTH'(2);
  localparam int unsigned            TOP         = COUNT_WIDTH - 1;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] initial_count_r;
  logic [FINE_W-1:0]     fine_bits_r;

  // Search state.
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [COUNT_WIDTH-1:0] probe_r, probe_nxt;
  logic [1:0]             stage_r, stage_nxt;
  logic [DBL_W-1:0]       dbl_r, dbl_nxt;
  logic [FINE_W-1:0]      fine_done_r, fine_done_nxt;

  // Output register.
  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic in_accept;

  // The output register frees up in the same cycle its word is taken.
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.trial_count = res_r.trial_count;
  assign out_ch.done_res    = res_r.done_res;
  assign out_ch.overflow    = res_r.overflow;

  // Count values leave the block zero-extended or cut to the output width.
  function automatic logic [TRIAL_W-1:0] to_trial(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] wide;
    wide = 64'(c);
    return wide[TRIAL_W-1:0];
  endfunction

  always_comb begin
    logic [63:0]            init_wide;
    logic [COUNT_WIDTH-1:0] start_cnt;
    logic [COUNT_WIDTH-1:0] dbl_src;
    logic                   do_double;
    logic [COUNT_WIDTH-1:0] fn_cnt;
    logic [COUNT_WIDTH-1:0] fn_probe;
    logic [FINE_W-1:0]      fn_fd;
    logic [COUNT_WIDTH-1:0] fn_next;
    logic                   do_fine;
    logic                   cnt_dbl;

    count_nxt     = count_r;
    probe_nxt     = probe_r;
    stage_nxt     = stage_r;
    dbl_nxt       = dbl_r;
    fine_done_nxt = fine_done_r;
    res_nxt       = '{trial_count: to_trial(count_r), done_res: 1'b0, overflow: 1'b0};

    // The starting count is cut to the count width; zero counts as one.
    init_wide = 64'(initial_count_r);
    start_cnt = init_wide[COUNT_WIDTH-1:0];
    if (start_cnt == '0) begin
      start_cnt = CNT_ONE;
    end

    do_double = 1'b0;
    cnt_dbl   = 1'b0;
    dbl_src   = count_r;
    do_fine   = 1'b0;
    fn_cnt    = count_r;
    fn_probe  = probe_r;
    fn_fd     = fine_done_r;

    if (in_accept) begin
      if (in_ch.mode == MODE_START) begin
        probe_nxt     = '0;
        dbl_nxt       = '0;
        fine_done_nxt = '0;
        dbl_src       = start_cnt;
        count_nxt     = start_cnt;
        do_double     = 1'b1;
      end else begin
        unique case (stage_r)
          ST_COARSE: begin
            if (!in_ch.tick_passed) begin
              do_double = 1'b1;
              cnt_dbl   = 1'b1;
            end else if (dbl_r == '0) begin
              // A tick on the very first trial: restart the search from one, doubled.
              count_nxt = CNT_RESTART;
              dbl_nxt   = DBL_W'(1);
              res_nxt   = '{trial_count: to_trial(CNT_RESTART), done_res: 1'b0,
                            overflow: 1'b0};
            end else begin
              // Back off to the lower bound and start refining below its top bit.
              fn_cnt   = count_r >> 1;
              fn_probe = count_r >> 1;
              fn_fd    = '0;
              do_fine  = 1'b1;
            end
          end
          ST_FINE: begin
            fn_cnt  = in_ch.tick_passed ? (count_r & ~probe_r) : count_r;
            do_fine = 1'b1;
          end
          ST_DONE: begin
            res_nxt.done_res = 1'b1;
          end
          ST_IDLE: begin
          end
          default: begin
          end
        endcase
      end
    end

    if (do_double) begin
      if (dbl_src[TOP]) begin
        // Doubling would pass the top bit: stop with the count held.
        count_nxt = dbl_src;
        stage_nxt = ST_IDLE;
        res_nxt   = '{trial_count: to_trial(dbl_src), done_res: 1'b1, overflow: 1'b1};
      end else begin
        count_nxt = dbl_src << 1;
        stage_nxt = ST_COARSE;
        res_nxt   = '{trial_count: to_trial(dbl_src << 1), done_res: 1'b0,
                      overflow: 1'b0};
        if (cnt_dbl && dbl_r != DBL_MAX) begin
          dbl_nxt = dbl_r + DBL_W'(1);
        end
      end
    end

    fn_next = fn_probe >> 1;
    if (do_fine) begin
      if (fn_fd >= fine_bits_r || fn_next == '0) begin
        count_nxt     = fn_cnt;
        probe_nxt     = fn_probe;
        fine_done_nxt = fn_fd;
        stage_nxt     = ST_DONE;
        res_nxt       = '{trial_count: to_trial(fn_cnt), done_res: 1'b1, overflow: 1'b0};
      end else begin
        count_nxt     = fn_cnt | fn_next;
        probe_nxt     = fn_next;
        fine_done_nxt = fn_fd + FINE_W'(1);
        stage_nxt     = ST_FINE;
        res_nxt       = '{trial_count: to_trial(fn_cnt | fn_next), done_res: 1'b0,
                          overflow: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_count_r <= INITIAL_COUNT_RST;
      fine_bits_r     <= FINE_BITS_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_INITIAL_COUNT: initial_count_r <= cfg_ch.data;
        REG_FINE_BITS:     fine_bits_r     <= cfg_ch.data[FINE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      probe_r     <= '0;
      stage_r     <= ST_IDLE;
      dbl_r       <= '0;
      fine_done_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      probe_r     <= probe_nxt;
      stage_r     <= stage_nxt;
      dbl_r       <= dbl_nxt;
      fine_done_r <= fine_done_nxt;
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is loaded with each accepted word.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- tb/tb_delay_count_calibration_search.sv -----
`timescale 1ns / 100ps

// Keeps its own copy of the search sequencer state and configuration, works out
// the trial word that each accepted input word causes, and checks the result words
// against those trial words in order.
class calib_search_scoreboard;

  typedef enum logic [1:0] {
    STG_IDLE,
    STG_COARSE,
    STG_FINE,
    STG_DONE
  } stage_e;

  logic [dcs_pkg::TRIAL_W-1:0] start_count;
  logic [dcs_pkg::FINE_W-1:0]  refine_bits;

  logic [dcs_pkg::TRIAL_W-1:0] count;
  logic [dcs_pkg::TRIAL_W-1:0] probe;
  stage_e                      stage;
  logic [dcs_pkg::DBL_W-1:0]   doublings;
  logic [dcs_pkg::FINE_W-1:0]  refined;

  dcs_pkg::result_t pending_trials[$];
  int unsigned      fails;

  function new();
    start_count = dcs_pkg::INITIAL_COUNT_RST;
    refine_bits = dcs_pkg::FINE_BITS_RST;
    count       = '0;
    probe       = '0;
    stage       = STG_IDLE;
    doublings   = '0;
    refined     = '0;
    fails       = 0;
  endfunction

  function int unsigned pending();
    return pending_trials.size();
  endfunction

  function void write_reg(logic [dcs_pkg::CFG_IDX_W-1:0] idx,
                          logic [dcs_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      dcs_pkg::REG_INITIAL_COUNT: start_count = data;
      dcs_pkg::REG_FINE_BITS:     refine_bits = data[dcs_pkg::FINE_W-1:0];
      default: ;
    endcase
  endfunction

  // Doubles the count for the next coarse trial, or stops when the top bit is set.
  function dcs_pkg::result_t climb();
    if (count[dcs_pkg::TRIAL_W-1]) begin
      stage = STG_IDLE;
      return {count, 1'b1, 1'b1};
    end
    count = count << 1;
    stage = STG_COARSE;
    return {count, 1'b0, 1'b0};
  endfunction

  // Sets the next lower bit for a trial, or ends the search.
  function dcs_pkg::result_t refine();
    logic [dcs_pkg::TRIAL_W-1:0] next_bit;
    next_bit = probe >> 1;
    if (refined >= refine_bits || next_bit == '0) begin
      stage = STG_DONE;
      return {count, 1'b1, 1'b0};
    end
    probe   = next_bit;
    count   = count | probe;
    refined = refined + 1'b1;
    stage   = STG_FINE;
    return {count, 1'b0, 1'b0};
  endfunction

  function void predict_next_trial(logic mode, logic tick);
    dcs_pkg::result_t res;
    if (mode == dcs_pkg::MODE_START) begin
      count = (start_count == '0) ? 1 : start_count;
      probe     = '0;
      doublings = '0;
      refined   = '0;
      res = climb();
    end else begin
      case (stage)
        STG_COARSE: begin
          if (!tick) begin
            res = climb();
            if (stage == STG_COARSE && doublings < dcs_pkg::DBL_MAX)
              doublings = doublings + 1'b1;
          end else if (doublings == '0) begin
            count     = 2;
            doublings = dcs_pkg::DBL_W'(1);
            res = {count, 1'b0, 1'b0};
          end else begin
            count   = count >> 1;
            probe   = count;
            refined = '0;
            res = refine();
          end
        end
        STG_FINE: begin
          if (tick)
            count = count & ~probe;
          res = refine();
        end
        STG_DONE: res = {count, 1'b1, 1'b0};
        default:  res = {count, 1'b0, 1'b0};
      endcase
    end
    pending_trials.push_back(res);
  endfunction

  task report(string msg);
    if (fails < 100)
      $display("[%0t] MISMATCH: %s", $time, msg);
    fails++;
  endtask

  task check_trial(dcs_pkg::result_t got);
    dcs_pkg::result_t want;
    if (pending_trials.size() == 0) begin
      report($sformatf("result word with nothing expected: count=%h done=%b ovf=%b",
                       got.trial_count, got.done_res, got.overflow));
      return;
    end
    want = pending_trials.pop_front();
    if (got.trial_count !== want.trial_count)
      report($sformatf("trial_count %h, expected %h", got.trial_count, want.trial_count));
    if (got.done_res !== want.done_res)
      report($sformatf("done_res %b, expected %b (count %h)", got.done_res, want.done_res,
                       want.trial_count));
    if (got.overflow !== want.overflow)
      report($sformatf("overflow %b, expected %b (count %h)", got.overflow, want.overflow,
                       want.trial_count));
  endtask

endclass

module tb_delay_count_calibration_search;
  import dcs_pkg::*;

  // The random part ends with the phase in which this many further input words have been taken.
  localparam int unsigned RANDOM_WORDS = 650;
  // Hard ceiling on the run.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Length of the single long hold-off on the result side.
  localparam int unsigned HOLD_CYCLES  = 400;

  logic clk;
  logic rst_n;

  dcs_in_if  in_ch();
  dcs_out_if out_ch();
  dcs_cfg_if cfg_ch();

  delay_count_calibration_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  calib_search_scoreboard sb;

  int unsigned words_sent;
  int unsigned cycle_cnt;
  // While quiet is set neither side idles. hold_go asks the result side for its
  // one long hold-off.
  logic        quiet;
  logic        hold_go;

  // A 2 ns clock.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a run that hangs ends here as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side. Every signal checked here is driven with a nonblocking assignment at
  // the rising edge, so values read at the edge are the ones the block saw.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_trial({out_ch.trial_count, out_ch.done_res, out_ch.overflow});
  end

  // The result side takes words at random, ready with a chance of about 73 in a hundred. Once, when
  // asked, it holds off for a long stretch so the output register fills up and the
  // block pushes back on the input side while the sender keeps offering words.
  initial begin : receiver
    bit          hold_done;
    int unsigned held;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++)
          @(posedge clk);
        hold_done = 1'b1;
      end
      out_ch.ready <= quiet || ($urandom_range(0, 99) >= 27);
    end
  end

  // Offers one input word and returns at the edge where it is taken. Valid stays
  // high into the next word unless a random gap is drawn, so back-to-back words
  // are common and valid never falls and rises in the same step.
  task automatic send_word(input logic mode, input logic tick);
    if (!quiet && $urandom_range(0, 99) < 27) begin
      in_ch.valid <= 1'b0;
      do
        @(posedge clk);
      while ($urandom_range(0, 99) < 27);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.tick_passed <= tick;
    do
      @(posedge clk);
    while (in_ch.ready !== 1'b1);
    sb.predict_next_trial(mode, tick);
    words_sent++;
  endtask

  // Lets the block drain completely, then writes both registers back to back.
  // Every input word causes exactly one result word, so an empty store of
  // expected words means the block is idle.
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] seed_count,
                             input logic [CFG_DATA_W-1:0] fine_word);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_INITIAL_COUNT;
    cfg_ch.data  <= seed_count;
    do
      @(posedge clk);
    while (cfg_ch.ready !== 1'b1);
    sb.write_reg(REG_INITIAL_COUNT, seed_count);
    cfg_ch.index <= REG_FINE_BITS;
    cfg_ch.data  <= fine_word;
    do
      @(posedge clk);
    while (cfg_ch.ready !== 1'b1);
    sb.write_reg(REG_FINE_BITS, fine_word);
    cfg_ch.valid <= 1'b0;
  endtask

  // One well-formed search: a start, a run of trials without a tick, the trial
  // that sees the tick, then fine trials with random outcomes. Most climbs are
  // short; now and then a long one runs into the top bit. A climb of zero gives
  // the tick on the very first trial, which restarts the count from one, doubled.
  task automatic run_search();
    int unsigned climbs;
    int unsigned fine_trials;
    climbs = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 34) : $urandom_range(0, 8);
    fine_trials = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 34)
                                              : $urandom_range(0, 14);
    send_word(MODE_START, 1'($urandom_range(0, 1)));
    repeat (climbs) send_word(MODE_REPORT, 1'b0);
    send_word(MODE_REPORT, 1'b1);
    repeat (fine_trials) send_word(MODE_REPORT, 1'($urandom_range(0, 1)));
  endtask

  // Noise: words of any kind, which also abort searches midway with a new start.
  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin : main_seq
    logic [CFG_DATA_W-1:0] seed_count;
    logic [CFG_DATA_W-1:0] fine_word;
    int unsigned           k;
    int unsigned           target;

    sb = new();
    words_sent = 0;
    cycle_cnt  = 0;
    quiet   <= 1'b0;
    hold_go <= 1'b0;
    rst_n   <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_START;
    in_ch.tick_passed <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_INITIAL_COUNT;
    cfg_ch.data  <= '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first with the reset configuration (4096, 8 fine bits).
    // A report before any start only echoes the zero count.
    send_word(MODE_REPORT, 1'b1);
    // A start ignores its tick flag and doubles 4096.
    send_word(MODE_START, 1'b1);
    send_word(MODE_REPORT, 1'b0);
    // The tick halves the count and the fine stage begins; nine more trials run
    // through all eight fine bits and then report the finished search once more.
    send_word(MODE_REPORT, 1'b1);
    for (k = 0; k < 9; k++)
      send_word(MODE_REPORT, k[0]);
    // A tick on the very first trial restarts from one, doubled to a count of two.
    send_word(MODE_START, 1'b0);
    send_word(MODE_REPORT, 1'b1);

    // All ones: the start already has the top bit set and overflows at once;
    // the report after it sees an idle block. Fine bits at its maximum.
    reconfigure('1, '1);
    send_word(MODE_START, 1'b0);
    send_word(MODE_REPORT, 1'b0);

    // A zero starting count is taken as one; no fine bits at all.
    reconfigure('0, '0);
    send_word(MODE_START, 1'b0);
    send_word(MODE_REPORT, 1'b1);
    send_word(MODE_REPORT, 1'b0);
    send_word(MODE_REPORT, 1'b1);

    // A starting count that is not a power of two is used as given; the fine
    // stage runs out of lower bits before it runs out of fine bits.
    reconfigure(32'd3, 32'd31);
    send_word(MODE_START, 1'b0);
    send_word(MODE_REPORT, 1'b0);
    send_word(MODE_REPORT, 1'b1);
    send_word(MODE_REPORT, 1'b1);
    send_word(MODE_REPORT, 1'b0);

    // Random part: each phase picks a new configuration, extremes included,
    // then runs a handful of searches with some noise mixed in.
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      case ($urandom_range(0, 9))
        0:       seed_count = 32'd1;
        1:       seed_count = 32'h8000_0000;
        2:       seed_count = '0;
        3:       seed_count = $urandom;
        4:       seed_count = '1;
        default: seed_count = 32'd1 << $urandom_range(0, 20);
      endcase
      fine_word = $urandom;
      case ($urandom_range(0, 5))
        0:       fine_word[FINE_W-1:0] = '0;
        1:       fine_word[FINE_W-1:0] = '1;
        default: fine_word[FINE_W-1:0] = FINE_W'($urandom_range(0, 12));
      endcase
      reconfigure(seed_count, fine_word);

      repeat ($urandom_range(2, 5)) begin
        // Ask once for the long hold-off right before a full search, so the
        // sender keeps offering words while the result side holds off.
        if (words_sent >= target - RANDOM_WORDS + 200 && !hold_go) begin
          hold_go <= 1'b1;
          run_search();
        end else if ($urandom_range(0, 99) < 85)
          run_search();
        else
          send_noise();
        // Keep a stretch with no idling.
        quiet <= (words_sent >= target - RANDOM_WORDS + 300) &&
                 (words_sent <  target - RANDOM_WORDS + 420);
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    // The wait that follows catches any stray result word.
    repeat (4) @(posedge clk);

    if (sb.fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
src/dcs_pkg.sv
src/dcs_in_if.sv
src/dcs_out_if.sv
src/dcs_cfg_if.sv
src/delay_count_calibration_search.sv
tb/tb_delay_count_calibration_search.sv
